// ===== rtl/core/fcv_pkg.sv =====
// Shared definitions for the fixed-capacity vector: sizes, field widths,
// operation and status codes, and the structs passed between its modules.
// No dependencies.
package fcv_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;

  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [MODE_W-1:0] MODE_PUSH        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP         = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ERASE       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ERASE_RANGE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ        = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CLEAR       = 3'd6;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [POS_W-1:0]          position;
    logic [POS_W-1:0]          position_end;
    logic signed [VALUE_W-1:0] value;
  } fcv_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_word;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
  } fcv_res_t;

  typedef struct packed {
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
  } fcv_mem_req_t;

endpackage

// ===== rtl/core/fcv_in_if.sv =====
// Input channel of the fixed-capacity vector: valid/ready handshake and
// the operation fields. Depends on fcv_pkg.
interface fcv_in_if;
  import fcv_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [POS_W-1:0]          position;
  logic [POS_W-1:0]          position_end;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, mode, position, position_end, value, input ready);
  modport sink (input valid, mode, position, position_end, value, output ready);
endinterface

// ===== rtl/core/fcv_out_if.sv =====
// Result channel of the fixed-capacity vector: valid/ready handshake and
// the result fields. Depends on fcv_pkg.
interface fcv_out_if;
  import fcv_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] read_word;
  logic [COUNT_W-1:0]        count;
  logic                      is_empty;

  modport source (output valid, status, read_word, count, is_empty, input ready);
  modport sink (input valid, status, read_word, count, is_empty, output ready);
endinterface

// ===== rtl/core/fcv_store.sv =====
// Element storage: one write port and one read port with registered data.
// Depends on fcv_pkg.
module fcv_store (
  input  logic                          clk,
  input  fcv_pkg::fcv_mem_req_t         req,
  output logic [fcv_pkg::WORD_BITS-1:0] rd_data
);
  import fcv_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== rtl/core/fcv_seq.sv =====
// Sequencer of the fixed-capacity vector: decodes an item, keeps the element
// count and moves stored words one per cycle through the storage ports.
// Depends on fcv_pkg.
module fcv_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fcv_pkg::fcv_item_t            item,
  output logic                          res_valid,
  input  logic                          res_free,
  output fcv_pkg::fcv_res_t             res,
  output fcv_pkg::fcv_mem_req_t         mem_req,
  input  logic [fcv_pkg::WORD_BITS-1:0] rd_data
);
  import fcv_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_PUTV  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]    src_r, src_nxt;
  logic [ADDR_W-1:0]    last_r, last_nxt;
  logic [ADDR_W-1:0]    gap_r, gap_nxt;
  logic [ADDR_W-1:0]    pdst_r, pdst_nxt;
  logic [ADDR_W-1:0]    pos_r, pos_nxt;
  logic                 up_r, up_nxt;
  logic                 pend_r, pend_nxt;
  logic                 rdflag_r, rdflag_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [WORD_BITS-1:0] val_r, val_nxt;

  logic [CMP_W-1:0]     c, p, e, e1;
  logic [WORD_BITS-1:0] in_word;
  logic                 full;

  assign c       = CMP_W'(cnt_r);
  assign p       = CMP_W'(item.position);
  assign e       = CMP_W'(item.position_end);
  assign e1      = p + CMP_W'(1);
  assign in_word = WORD_BITS'(item.value);
  assign full    = (c >= CMP_W'(DEPTH));

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    src_nxt    = src_r;
    last_nxt   = last_r;
    gap_nxt    = gap_r;
    pdst_nxt   = pdst_r;
    pos_nxt    = pos_r;
    up_nxt     = up_r;
    pend_nxt   = 1'b0;
    rdflag_nxt = rdflag_r;
    status_nxt = status_r;
    val_nxt    = val_r;
    mem_req    = '0;
    in_ready   = (state_r == ST_IDLE);
    res_valid  = 1'b0;

    // A word read in the previous cycle is written to its new place now.
    if (pend_r) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = pdst_r;
      mem_req.wr_data = rd_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          status_nxt = STATUS_OK;
          rdflag_nxt = 1'b0;
          state_nxt  = ST_DONE;
          unique case (item.mode)
            MODE_PUSH: begin
              if (full) begin
                status_nxt = STATUS_FULL;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ADDR_W'(cnt_r);
                mem_req.wr_data = in_word;
                cnt_nxt         = cnt_r + CNT_W'(1);
              end
            end
            MODE_POP: begin
              if (cnt_r == '0) begin
                status_nxt = STATUS_EMPTY;
              end else begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            MODE_INSERT: begin
              if (full) begin
                status_nxt = STATUS_FULL;
              end else if (p > c) begin
                status_nxt = STATUS_RANGE;
              end else begin
                cnt_nxt = cnt_r + CNT_W'(1);
                if (p == c) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = ADDR_W'(p);
                  mem_req.wr_data = in_word;
                end else begin
                  // Move the tail up, last entry first, then place the word.
                  src_nxt   = ADDR_W'(c - CMP_W'(1));
                  last_nxt  = ADDR_W'(p);
                  up_nxt    = 1'b1;
                  val_nxt   = in_word;
                  pos_nxt   = ADDR_W'(p);
                  state_nxt = ST_SHIFT;
                end
              end
            end
            MODE_ERASE: begin
              if (p >= c) begin
                status_nxt = STATUS_RANGE;
              end else begin
                cnt_nxt = cnt_r - CNT_W'(1);
                if (e1 != c) begin
                  src_nxt   = ADDR_W'(e1);
                  last_nxt  = ADDR_W'(c - CMP_W'(1));
                  gap_nxt   = ADDR_W'(1);
                  up_nxt    = 1'b0;
                  state_nxt = ST_SHIFT;
                end
              end
            end
            MODE_ERASE_RANGE: begin
              if (p > e || e > c) begin
                status_nxt = STATUS_RANGE;
              end else begin
                cnt_nxt = CNT_W'(c - (e - p));
                if (e != p && e != c) begin
                  src_nxt   = ADDR_W'(e);
                  last_nxt  = ADDR_W'(c - CMP_W'(1));
                  gap_nxt   = ADDR_W'(e - p);
                  up_nxt    = 1'b0;
                  state_nxt = ST_SHIFT;
                end
              end
            end
            MODE_READ: begin
              if (p >= c) begin
                status_nxt = STATUS_RANGE;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ADDR_W'(p);
                rdflag_nxt      = 1'b1;
              end
            end
            MODE_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = src_r;
        pend_nxt        = 1'b1;
        pdst_nxt        = up_r ? (src_r + ADDR_W'(1)) : (src_r - gap_r);
        if (src_r == last_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          src_nxt = up_r ? (src_r - ADDR_W'(1)) : (src_r + ADDR_W'(1));
        end
      end
      ST_DRAIN: begin
        state_nxt = up_r ? ST_PUTV : ST_DONE;
      end
      ST_PUTV: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_r;
        mem_req.wr_data = val_r;
        state_nxt       = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status    = status_r;
    res.read_word = rdflag_r ? VALUE_W'(signed'(rd_data)) : '0;
    res.count     = COUNT_W'(cnt_r);
    res.is_empty  = (cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      pend_r   <= 1'b0;
      rdflag_r <= 1'b0;
      status_r <= STATUS_OK;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      rdflag_r <= rdflag_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    last_r <= last_nxt;
    gap_r  <= gap_nxt;
    pdst_r <= pdst_nxt;
    pos_r  <= pos_nxt;
    up_r   <= up_nxt;
    val_r  <= val_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("element count exceeds capacity");

  a_no_move_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> !pend_r)
    else $error("word move pending outside a shift");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && item.mode == MODE_PUSH && !full)
      |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("push did not raise the count");

  a_shift_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && src_r == last_r) |=> state_r == ST_DRAIN)
    else $error("shift did not end at its last entry");
`endif

endmodule

// ===== rtl/core/fixed_capacity_vector.sv =====
// Fixed-capacity ordered vector of DEPTH words with push, pop, insert, erase,
// range erase, checked read and clear.
// Items that move no words go from acceptance straight to the result state;
// items that move words pass through SHIFT and DRAIN first, and insert then
// writes its word in PUTV. A new item is accepted only after the last result
// enters the result register; words move one per cycle through the single storage read port.
// Reset (synchronous, rst_n low) empties the vector; stored words are not cleared.
module fixed_capacity_vector (
  input  logic      clk,
  input  logic      rst_n,
  fcv_in_if.sink    in_ch,
  fcv_out_if.source out_ch
);
  import fcv_pkg::*;

  fcv_item_t            item;
  fcv_res_t             res;
  fcv_mem_req_t         mem_req;
  logic [WORD_BITS-1:0] rd_data;
  logic                 in_ready;
  logic                 res_valid;
  logic                 res_free;

  logic                 out_valid_r, out_valid_nxt;
  fcv_res_t             out_res_r, out_res_nxt;

  assign item.mode         = in_ch.mode;
  assign item.position     = in_ch.position;
  assign item.position_end = in_ch.position_end;
  assign item.value        = in_ch.value;
  assign in_ch.ready       = in_ready;

  // The result register frees itself in the same cycle it is taken.
  assign res_free = !out_valid_r || out_ch.ready;

  fcv_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .item     (item),
    .res_valid(res_valid),
    .res_free (res_free),
    .res      (res),
    .mem_req  (mem_req),
    .rd_data  (rd_data)
  );

  fcv_store u_store (
    .clk    (clk),
    .req    (mem_req),
    .rd_data(rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_free) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_res_r.status;
  assign out_ch.read_word = out_res_r.read_word;
  assign out_ch.count     = out_res_r.count;
  assign out_ch.is_empty  = out_res_r.is_empty;

endmodule
